### design/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, register codes and sine helper functions for the stereo
// chorus delay unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

  // Sequencer states. Each channel runs LFO through MIX once per transaction.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LFO,
    ST_DEPTH,
    ST_ADDR,
    ST_RD1,
    ST_RD2,
    ST_INTERP,
    ST_WET,
    ST_DRY,
    ST_MIX,
    ST_OUT
  } scd_state_e;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_DEPTH_L   = 3'd0,
    REG_DEPTH_R   = 3'd1,
    REG_BASE_L    = 3'd2,
    REG_BASE_R    = 3'd3,
    REG_RATE_L    = 3'd4,
    REG_RATE_R    = 3'd5,
    REG_MIX       = 3'd6,
    REG_START_PH  = 3'd7
  } scd_reg_e;

  localparam logic [15:0] MIX_ONE    = 16'd32768;
  localparam logic [31:0] SAT_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN    = 32'h8000_0001;

  // Polynomial quarter sine on a Q15 offset, floors throughout.
  function automatic logic [15:0] quarter_wave(input logic [15:0] z);
    logic [63:0] z2;
    logic [63:0] t;
    z2 = ({48'd0, z} * {48'd0, z}) >> 15;
    t  = (64'd2320 * z2) >> 15;
    t  = 64'd21023 - t;
    t  = (t * z2) >> 15;
    t  = 64'd51472 - t;
    t  = (t * {48'd0, z}) >> 15;
    if (t > 64'd32767) begin
      t = 64'd32767;
    end
    return t[15:0];
  endfunction

  // Full-wave sine from the 17-bit position within one turn.
  function automatic logic signed [15:0] sine_of_pos(input logic [16:0] u);
    logic [15:0] z;
    logic [15:0] y;
    z = {1'b0, u[14:0]};
    case (u[16:15])
      2'd0:    y = quarter_wave(z);
      2'd1:    y = quarter_wave(16'd32768 - z);
      2'd2:    y = quarter_wave(z);
      default: y = quarter_wave(16'd32768 - z);
    endcase
    if (u[16]) begin
      return -$signed(y);
    end
    return $signed(y);
  endfunction

endpackage

`default_nettype wire

### design/scd_if.sv
// ----------------------------------------------------------------------------
// scd_if
// Valid/ready stream interfaces for sample pairs entering and leaving the
// chorus.
// ----------------------------------------------------------------------------
`default_nettype none

interface scd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_in;
  logic signed [31:0] right_in;

  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface scd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_out;
  logic signed [31:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

### design/stereo_chorus_delay_unit.sv
// ----------------------------------------------------------------------------
// stereo_chorus_delay_unit
// Stereo LFO-modulated chorus with linear tap interpolation and dry/wet mix.
// ----------------------------------------------------------------------------
// Usage. Sample pairs arrive on in_sink as valid/ready transactions and the
// mixed pairs leave on out_src, one result transaction per input transaction.
// Registers must be written through the APB-style port while the block is
// idle, unenforced by it; a start-phase write reloads both LFO phases at once.
//
// Timing. A transaction is accepted in the idle state, then one sequencer
// walks the left and then the right channel through nine steps each, all
// sharing a single 34 x 18 multiplier and one read port of the delay stores.
// The result is presented once both channels are done; the next pair can be
// accepted once that result is in the output register, and no new pair is
// taken before then, as the multiplier and the memory read port are shared.
//
// Stalls. The block is ready again as soon as a result is in the output
// register; if that result is still not taken when the next one is finished,
// the sequencer waits in its final step until the receiver takes it.
//
// Reset. The delay stores are not cleared: a fill flag and the write pointer
// tell which entries have been written, and unwritten entries read as zero,
// so the block is ready in the first cycle after reset. Registers take their
// default values and both LFO phases load from the zero start phase.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_chorus_delay_unit
  import scd_pkg::*;
#(
  parameter int unsigned DELAY_DEPTH     = 2048,
  parameter int unsigned SINE_TABLE_SIZE = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  scd_in_if.sink           in_sink,
  scd_out_if.source        out_src,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int IW  = $clog2(SINE_TABLE_SIZE);
  localparam int SW  = $clog2(SINE_TABLE_SIZE + 1);
  localparam int PW  = 32 + SW;
  // Width of the Q.8 delay and read position arithmetic, with a sign bit.
  localparam int DW  = (AW + 10 > 22) ? AW + 10 : 22;
  localparam logic signed [DW-1:0] MaxDelay = DW'((DELAY_DEPTH - 2) * 256);
  localparam logic signed [DW-1:0] Span     = DW'(DELAY_DEPTH * 256);
  localparam logic [AW:0]          DepthW   = (AW + 1)'(DELAY_DEPTH);

  // Configuration registers.
  logic [15:0] depth_l_q, depth_r_q, mix_q;
  logic [10:0] base_l_q, base_r_q;
  logic [31:0] rate_l_q, rate_r_q, start_q;

  // Channel state.
  logic [31:0]  phase_l_q, phase_r_q;
  logic [AW-1:0] wp_q;
  logic          full_q;

  // Sequencer and working registers.
  scd_state_e state_q, state_d;
  logic              ch_q;
  logic signed [31:0] in_l_q, in_r_q;
  logic [AW-1:0]     t1_q, t2_q;
  logic              t1_vld_q, t2_vld_q, rd_vld_q;
  logic [7:0]        frac_q;
  logic signed [31:0] s1_q;
  logic signed [33:0] wet_q;
  logic signed [51:0] acc_q;
  logic signed [31:0] res_l_q, res_r_q;
  logic              out_valid_q;
  logic signed [31:0] out_l_q, out_r_q;

  wire logic cfg_wr = psel & penable & pwrite;
  wire logic in_acc = in_sink.valid & in_sink.ready;
  wire logic wp_last = ({1'b0, wp_q} + 1'b1) >= DepthW;

  assign pready = 1'b1;

  always_comb begin
    unique case (scd_reg_e'(paddr[4:2]))
      REG_DEPTH_L:  prdata = {16'd0, depth_l_q};
      REG_DEPTH_R:  prdata = {16'd0, depth_r_q};
      REG_BASE_L:   prdata = {21'd0, base_l_q};
      REG_BASE_R:   prdata = {21'd0, base_r_q};
      REG_RATE_L:   prdata = rate_l_q;
      REG_RATE_R:   prdata = rate_r_q;
      REG_MIX:      prdata = {16'd0, mix_q};
      REG_START_PH: prdata = start_q;
      default:      prdata = 32'd0;
    endcase
  end

  // Wet gain, with anything above unity taken as fully wet.
  wire logic [15:0] wgain = (mix_q > MIX_ONE) ? MIX_ONE : mix_q;

  // Per-channel selections.
  wire logic [31:0]        phase_sel = ch_q ? phase_r_q : phase_l_q;
  wire logic [15:0]        depth_sel = ch_q ? depth_r_q : depth_l_q;
  wire logic [10:0]        base_sel  = ch_q ? base_r_q  : base_l_q;
  wire logic signed [31:0] dry_sel   = ch_q ? in_r_q    : in_l_q;

  // Sine table index: the top bits of phase scaled by the table size.
  logic [PW-1:0] idx_prod;
  logic [IW-1:0] sine_addr;
  logic signed [15:0] sine_rd;
  assign idx_prod  = PW'(phase_sel) * PW'(SINE_TABLE_SIZE);
  assign sine_addr = idx_prod[32 +: IW];

  scd_sine_rom #(.SINE_TABLE_SIZE(SINE_TABLE_SIZE)) u_rom (
    .clk_i  (clk_i),
    .addr_i (sine_addr),
    .data_o (sine_rd)
  );

  // Shared multiplier and its operand selection.
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod;

  scd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Delay store access.
  logic [31:0] rd_l, rd_r;
  logic [AW-1:0] raddr;
  assign raddr = (state_q == ST_RD1) ? t1_q : t2_q;

  scd_delay_mem #(.DELAY_DEPTH(DELAY_DEPTH)) u_mem (
    .clk_i     (clk_i),
    .we_i      (in_acc),
    .waddr_i   (wp_q),
    .wdata_l_i (in_sink.left_in),
    .wdata_r_i (in_sink.right_in),
    .raddr_i   (raddr),
    .rdata_l_o (rd_l),
    .rdata_r_o (rd_r)
  );

  // Entries not yet written since reset read as zero.
  wire logic signed [31:0] tap_data = rd_vld_q ? $signed(ch_q ? rd_r : rd_l) : 32'sd0;

  // Delay and read position from the depth product.
  logic signed [DW-1:0] delay_raw, delay_c, rpos_raw, rpos;
  logic [AW-1:0] t1_w, t2_w;
  always_comb begin
    delay_raw = DW'({base_sel, 8'd0}) + DW'(prod >>> 15);
    if (delay_raw < 0) begin
      delay_c = '0;
    end else if (delay_raw > MaxDelay) begin
      delay_c = MaxDelay;
    end else begin
      delay_c = delay_raw;
    end
    rpos_raw = DW'({wp_q, 8'd0}) - delay_c;
    rpos = (rpos_raw < 0) ? rpos_raw + Span : rpos_raw;
    t1_w = rpos[8 +: AW];
    if ({1'b0, t1_w} >= DepthW) begin
      t1_w = '0;
    end
    t2_w = (({1'b0, t1_w} + 1'b1) >= DepthW) ? '0 : t1_w + 1'b1;
  end

  // Interpolated wet sample and the final rounded, saturated mix.
  logic signed [33:0] wet_w;
  logic signed [51:0] mix_sum;
  logic signed [36:0] mix_shift;
  logic signed [31:0] mix_sat;
  always_comb begin
    wet_w     = 34'(s1_q) + 34'(prod >>> 8);
    mix_sum   = acc_q + prod + 52'sd16384;
    mix_shift = 37'(mix_sum >>> 15);
    if (mix_shift > 37'(signed'(SAT_MAX))) begin
      mix_sat = signed'(SAT_MAX);
    end else if (mix_shift < 37'(signed'(SAT_MIN))) begin
      mix_sat = signed'(SAT_MIN);
    end else begin
      mix_sat = mix_shift[31:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_DEPTH: begin
        mul_a = 34'(sine_rd);
        mul_b = $signed({2'b00, depth_sel});
      end
      ST_INTERP: begin
        mul_a = 34'(tap_data) - 34'(s1_q);
        mul_b = $signed({10'd0, frac_q});
      end
      ST_WET: begin
        mul_a = 34'(dry_sel);
        mul_b = $signed({2'b00, MIX_ONE - wgain});
      end
      ST_DRY: begin
        mul_a = wet_q;
        mul_b = $signed({2'b00, wgain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_LFO;
      ST_LFO:    state_d = ST_DEPTH;
      ST_DEPTH:  state_d = ST_ADDR;
      ST_ADDR:   state_d = ST_RD1;
      ST_RD1:    state_d = ST_RD2;
      ST_RD2:    state_d = ST_INTERP;
      ST_INTERP: state_d = ST_WET;
      ST_WET:    state_d = ST_DRY;
      ST_DRY:    state_d = ST_MIX;
      ST_MIX:    state_d = ch_q ? ST_OUT : ST_LFO;
      ST_OUT:    if (!out_valid_q || out_src.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign in_sink.ready     = (state_q == ST_IDLE);
  assign out_src.valid     = out_valid_q;
  assign out_src.left_out  = out_l_q;
  assign out_src.right_out = out_r_q;

  wire logic out_load = (state_q == ST_OUT) && (!out_valid_q || out_src.ready);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      phase_l_q   <= '0;
      phase_r_q   <= '0;
      depth_l_q   <= 16'd2560;
      depth_r_q   <= 16'd2560;
      base_l_q    <= 11'd720;
      base_r_q    <= 11'd960;
      rate_l_q    <= 32'd134218;
      rate_r_q    <= 32'd143166;
      mix_q       <= 16'd16384;
      start_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        ch_q <= 1'b0;
      end else if (state_q == ST_MIX) begin
        ch_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        wp_q        <= wp_last ? '0 : wp_q + 1'b1;
        full_q      <= full_q | wp_last;
        phase_l_q   <= phase_l_q + rate_l_q;
        phase_r_q   <= phase_r_q + rate_r_q;
      end else if (out_src.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        case (scd_reg_e'(paddr[4:2]))
          REG_DEPTH_L:  depth_l_q <= pwdata[15:0];
          REG_DEPTH_R:  depth_r_q <= pwdata[15:0];
          REG_BASE_L:   base_l_q  <= pwdata[10:0];
          REG_BASE_R:   base_r_q  <= pwdata[10:0];
          REG_RATE_L:   rate_l_q  <= pwdata;
          REG_RATE_R:   rate_r_q  <= pwdata;
          REG_MIX:      mix_q     <= pwdata[15:0];
          REG_START_PH: begin
            start_q   <= pwdata;
            phase_l_q <= {pwdata[15:0], 16'd0};
            phase_r_q <= {pwdata[31:16], 16'd0};
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_l_q <= in_sink.left_in;
      in_r_q <= in_sink.right_in;
    end
    if (state_q == ST_ADDR) begin
      t1_q     <= t1_w;
      t2_q     <= t2_w;
      frac_q   <= rpos[7:0];
      t1_vld_q <= full_q || (t1_w <= wp_q);
      t2_vld_q <= full_q || (t2_w <= wp_q);
    end
    rd_vld_q <= (state_q == ST_RD1) ? t1_vld_q : t2_vld_q;
    if (state_q == ST_RD2) begin
      s1_q <= tap_data;
    end
    if (state_q == ST_WET) begin
      wet_q <= wet_w;
    end
    if (state_q == ST_DRY) begin
      acc_q <= prod;
    end
    if (state_q == ST_MIX) begin
      if (ch_q) begin
        res_r_q <= mix_sat;
      end else begin
        res_l_q <= mix_sat;
      end
    end
    if (out_load) begin
      out_l_q <= res_l_q;
      out_r_q <= res_r_q;
    end
  end

endmodule

`default_nettype wire

### design/scd_sine_rom.sv
// ----------------------------------------------------------------------------
// scd_sine_rom
// Constant sine table, built at elaboration, with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_sine_rom
  import scd_pkg::*;
#(
  parameter int unsigned SINE_TABLE_SIZE = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic [$clog2(SINE_TABLE_SIZE)-1:0] addr_i,
  output logic signed [15:0]                      data_o
);

  logic signed [15:0] rom_w [SINE_TABLE_SIZE];

  for (genvar i = 0; i < SINE_TABLE_SIZE; i++) begin : g_entry
    localparam int unsigned Pos = (i * 131072) / SINE_TABLE_SIZE;
    assign rom_w[i] = sine_of_pos(17'(Pos));
  end

  always_ff @(posedge clk_i) begin
    data_o <= rom_w[addr_i];
  end

endmodule

`default_nettype wire

### design/scd_delay_mem.sv
// ----------------------------------------------------------------------------
// scd_delay_mem
// Left and right circular delay stores sharing one write and one read
// address, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_delay_mem #(
  parameter int unsigned DELAY_DEPTH = 2048
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [$clog2(DELAY_DEPTH)-1:0] waddr_i,
  input  wire logic [31:0]                    wdata_l_i,
  input  wire logic [31:0]                    wdata_r_i,
  input  wire logic [$clog2(DELAY_DEPTH)-1:0] raddr_i,
  output logic [31:0]                         rdata_l_o,
  output logic [31:0]                         rdata_r_o
);

  logic [31:0] mem_l [DELAY_DEPTH];
  logic [31:0] mem_r [DELAY_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_l[waddr_i] <= wdata_l_i;
      mem_r[waddr_i] <= wdata_r_i;
    end
    rdata_l_o <= mem_l[raddr_i];
    rdata_r_o <= mem_r[raddr_i];
  end

endmodule

`default_nettype wire

### design/scd_mul.sv
// ----------------------------------------------------------------------------
// scd_mul
// Shared signed 34 x 18 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_mul (
  input  wire logic               clk_i,
  input  wire logic signed [33:0] a_i,
  input  wire logic signed [17:0] b_i,
  output logic signed [51:0]      p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= 52'(a_i) * 52'(b_i);
  end

endmodule

`default_nettype wire

### design/scd_checker.sv
// ----------------------------------------------------------------------------
// scd_checker
// Port-level checks for the stereo chorus delay unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic pready
);

  // A result waits until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped before it was taken");

  // Once a pair is taken the block is busy on it in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while still busy");

  // A new result never appears in the cycle right after an acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early after acceptance");

  // The configuration port never inserts wait states.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready deasserted");

endmodule

bind stereo_chorus_delay_unit scd_checker u_scd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_sink.valid),
  .in_ready  (in_sink.ready),
  .out_valid (out_src.valid),
  .out_ready (out_src.ready),
  .pready    (pready)
);

`default_nettype wire
